FILE: hdl/mlec_pkg.sv
// ----------------------------------------------------------------------------
// mlec_pkg: shared types and codes for the MAC learn event coalescer
// Command, result and operation codes, the slot record, cell status and control, FSM states.
// ----------------------------------------------------------------------------
package mlec_pkg;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_DEL   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_KEPT     = 3'd3;
    localparam logic [2:0] ST_DROPPED  = 3'd4;

    localparam logic [1:0] OPER_ADD  = 2'd0;
    localparam logic [1:0] OPER_DEL  = 2'd1;
    localparam logic [1:0] OPER_MOVE = 2'd2;

    typedef struct packed {
        logic [47:0] mac;
        logic [11:0] vlan;
        logic [2:0]  unit;
        logic [7:0]  port;
        logic [1:0]  oper;
    } t_entry;

    // per-cell report to the controller
    typedef struct packed {
        logic hit;
        logic same_port;
    } t_cell_stat;

    // controller commands broadcast to every cell
    typedef struct packed {
        logic   upd;      // write port/oper on the hit cell
        logic   rem;      // clear live on the hit cell
        logic   ins;      // write the event into cell ins_sel
        logic   shift;    // advance the drain chain by one
        logic   load;     // copy live entries into the drain chain
        logic   clr;      // clear every live bit
        t_entry ev;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVENT,
        S_LOAD,
        S_DRAIN
    } t_state;

endpackage

FILE: hdl/mac_learn_event_coalescer.sv
// ----------------------------------------------------------------------------
// mac_learn_event_coalescer: folds MAC learn/age events into a slot table
// A row of slot cells compares each event in parallel; a drain loads the
// live entries into a shift chain that empties through slot 0.
// ----------------------------------------------------------------------------
//  channel | handshake         | payload
//  event   | start / busy      | i_cmd i_mac i_vlan i_unit i_port i_move
//  result  | o_valid (strobe)  | o_kind o_status o_entry_* o_last
//
//  An add or delete is busy for its compare state after its accept edge; the
//  status beat follows in the next cycle, and a new item is taken only after it.
//  A flush loads the drain chain on its accept edge; an event that leaves every
//  slot used passes through the load state after the compare. The drain then
//  shifts the chain towards slot 0 up to the last live slot (at most CAPACITY
//  positions), or gives a single empty beat when nothing is live.
//  Synchronous active-low reset clears live bits, count and state.
//  Results are strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module mac_learn_event_coalescer #(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [47:0] i_mac,
    input  logic [11:0] i_vlan,
    input  logic [2:0]  i_unit,
    input  logic [7:0]  i_port,
    input  logic        i_move,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_status,
    output logic [47:0] o_entry_mac,
    output logic [11:0] o_entry_vlan,
    output logic [2:0]  o_entry_unit,
    output logic [7:0]  o_entry_port,
    output logic [1:0]  o_entry_oper,
    output logic        o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    mlec_pkg::t_state     r_state, n_state;
    mlec_pkg::t_cell_ctl  ctl;
    mlec_pkg::t_entry     r_ev, n_ev;
    logic [1:0]           r_cmd, n_cmd;
    logic [CW-1:0]        r_used, n_used;
    logic                 r_found, n_found;
    logic [IW:0]          r_cnt, n_cnt;

    mlec_pkg::t_cell_stat stat   [CAPACITY];
    logic                 hit_sel[CAPACITY];
    logic                 cvld   [CAPACITY+1];
    mlec_pkg::t_entry     cent   [CAPACITY+1];
    logic [CAPACITY-1:0]  hits;
    logic [CAPACITY-1:0]  rest_vld;
    logic                 any_hit;
    logic                 hit_same;

    logic                 r_valid, n_valid;
    logic [1:0]           r_kind, n_kind;
    logic [2:0]           r_status, n_status;
    mlec_pkg::t_entry     r_out, n_out;
    logic                 r_last, n_last;

    assign cvld[CAPACITY] = 1'b0;
    assign cent[CAPACITY] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            mlec_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_ins_sel   (r_used == CW'(g)),
                .i_hit_sel   (hit_sel[g]),
                .i_chain_vld (cvld[g+1]),
                .i_chain     (cent[g+1]),
                .o_chain_vld (cvld[g]),
                .o_chain     (cent[g]),
                .o_stat      (stat[g])
            );
            assign hits[g]     = stat[g].hit;
            // anything still queued behind slot 0
            assign rest_vld[g] = cvld[g+1];
        end
    endgenerate

    // first hit wins; keys are unique so at most one is set anyway
    always_comb begin
        logic seen;
        seen     = 1'b0;
        hit_same = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_sel[i] = hits[i] && !seen;
            if (hit_sel[i]) hit_same = stat[i].same_port;
            seen = seen | hits[i];
        end
    end
    assign any_hit = |hits;

    assign busy = r_state != mlec_pkg::S_IDLE;

    always_comb begin
        n_state  = r_state;
        n_ev     = r_ev;
        n_cmd    = r_cmd;
        n_used   = r_used;
        n_found  = r_found;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        n_kind   = mlec_pkg::KIND_STATUS;
        n_status = mlec_pkg::ST_INSERTED;
        n_out    = '0;
        n_last   = 1'b0;
        ctl      = '0;
        ctl.ev   = r_ev;
        case (r_state)
            mlec_pkg::S_IDLE: begin
                if (start && (i_cmd == mlec_pkg::CMD_ADD || i_cmd == mlec_pkg::CMD_DEL)) begin
                    n_cmd   = i_cmd;
                    n_ev.mac  = i_mac;
                    n_ev.vlan = i_vlan;
                    n_ev.unit = i_unit;
                    n_ev.port = i_port;
                    n_ev.oper = (i_cmd == mlec_pkg::CMD_DEL) ? mlec_pkg::OPER_DEL :
                                (i_move ? mlec_pkg::OPER_MOVE : mlec_pkg::OPER_ADD);
                    n_state = mlec_pkg::S_EVENT;
                end else if (start && i_cmd == mlec_pkg::CMD_FLUSH) begin
                    ctl.load = 1'b1;
                    n_found  = 1'b0;
                    n_cnt    = '0;
                    n_state  = mlec_pkg::S_DRAIN;
                end
            end
            mlec_pkg::S_EVENT: begin
                n_valid = 1'b1;
                if (any_hit) begin
                    if (r_cmd == mlec_pkg::CMD_DEL) begin
                        ctl.rem  = hit_same;
                        n_status = hit_same ? mlec_pkg::ST_REMOVED : mlec_pkg::ST_KEPT;
                    end else begin
                        ctl.upd  = 1'b1;
                        n_status = mlec_pkg::ST_UPDATED;
                    end
                end else if (r_used < CW'(CAPACITY)) begin
                    ctl.ins  = 1'b1;
                    n_used   = r_used + 1'b1;
                    n_status = mlec_pkg::ST_INSERTED;
                end else begin
                    n_status = mlec_pkg::ST_DROPPED;
                end
                if (n_used == CW'(CAPACITY)) begin
                    n_state = mlec_pkg::S_LOAD;
                end else begin
                    n_last  = 1'b1;
                    n_state = mlec_pkg::S_IDLE;
                end
            end
            mlec_pkg::S_LOAD: begin
                // the table is full and any write from the compare has landed; copy the live entries into the chain
                ctl.load = 1'b1;
                n_found  = 1'b0;
                n_cnt    = '0;
                n_state  = mlec_pkg::S_DRAIN;
            end
            mlec_pkg::S_DRAIN: begin
                ctl.shift = 1'b1;
                if (cvld[0]) begin
                    n_valid = 1'b1;
                    n_kind  = mlec_pkg::KIND_ENTRY;
                    n_out   = cent[0];
                    n_found = 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (IW+1)'(CAPACITY - 1) || !(|rest_vld)) begin
                    ctl.clr = 1'b1;
                    n_used  = '0;
                    n_last  = 1'b1;
                    n_state = mlec_pkg::S_IDLE;
                    if (!cvld[0] && !r_found) begin
                        n_valid = 1'b1;
                        n_kind  = mlec_pkg::KIND_EMPTY;
                    end
                end
            end
            default: n_state = mlec_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlec_pkg::S_IDLE;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_used  <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev     <= n_ev;
        r_cmd    <= n_cmd;
        r_found  <= n_found;
        r_cnt    <= n_cnt;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_out    <= n_out;
        r_last   <= n_last;
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_status     = r_status;
    assign o_entry_mac  = r_out.mac;
    assign o_entry_vlan = r_out.vlan;
    assign o_entry_unit = r_out.unit;
    assign o_entry_port = r_out.port;
    assign o_entry_oper = r_out.oper;
    assign o_last       = r_last;

endmodule

FILE: hdl/mlec_cell.sv
// ----------------------------------------------------------------------------
// mlec_cell: one table slot
// Holds an entry, compares it against the event key and forms one stage of
// the drain chain, passing its entry towards slot 0 on each shift.
// ----------------------------------------------------------------------------
module mlec_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mlec_pkg::t_cell_ctl  i_ctl,
    input  logic                 i_ins_sel,
    input  logic                 i_hit_sel,
    input  logic                 i_chain_vld,
    input  mlec_pkg::t_entry     i_chain,
    output logic                 o_chain_vld,
    output mlec_pkg::t_entry     o_chain,
    output mlec_pkg::t_cell_stat o_stat
);

    logic             r_live;
    mlec_pkg::t_entry r_ent;
    logic             r_dvld;
    mlec_pkg::t_entry r_dent;

    assign o_stat.hit = r_live && r_ent.mac == i_ctl.ev.mac
                        && r_ent.vlan == i_ctl.ev.vlan && r_ent.unit == i_ctl.ev.unit;
    assign o_stat.same_port = r_ent.port == i_ctl.ev.port;
    assign o_chain_vld = r_dvld;
    assign o_chain     = r_dent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_dvld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_live <= 1'b0;
            end else if (i_ctl.ins && i_ins_sel) begin
                r_live <= 1'b1;
            end else if (i_ctl.rem && i_hit_sel) begin
                r_live <= 1'b0;
            end
            if (i_ctl.load) begin
                r_dvld <= r_live;
            end else if (i_ctl.shift) begin
                r_dvld <= i_chain_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && i_ins_sel) begin
            r_ent <= i_ctl.ev;
        end else if (i_ctl.upd && i_hit_sel) begin
            r_ent.port <= i_ctl.ev.port;
            r_ent.oper <= i_ctl.ev.oper;
        end
        if (i_ctl.load) begin
            r_dent <= r_ent;
        end else if (i_ctl.shift) begin
            r_dent <= i_chain;
        end
    end

endmodule
